### rtl/cubic_bspline_point_generator_macros.svh
// Assertion macros shared by the B-spline point generator modules.
`ifndef CUBIC_BSPLINE_POINT_GENERATOR_MACROS_SVH
`define CUBIC_BSPLINE_POINT_GENERATOR_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising edge outside reset.
`define CBS_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cbs assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define CBS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cbs assertion failed");

`else

`define CBS_ASSERT_IMPL(name, clk, rst, ante, cons)
`define CBS_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

### rtl/cbs_pkg.sv
// Shared types and constants of the cubic B-spline point generator.
package cbs_pkg;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 5;

   localparam logic [CSR_INDEX_W-1:0] CSR_STEPS      = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLOSE_MODE = 4'd1;

   localparam logic [CSR_DATA_W-1:0] STEPS_RESET = 5'd6;

   // Point select codes: the window in age order, then head points one to three.
   // The codes are consecutive so a segment offset plus a tap number selects a point.
   localparam logic [2:0] SEL_W0 = 3'd0;
   localparam logic [2:0] SEL_W1 = 3'd1;
   localparam logic [2:0] SEL_W2 = 3'd2;
   localparam logic [2:0] SEL_W3 = 3'd3;
   localparam logic [2:0] SEL_H1 = 3'd4;
   localparam logic [2:0] SEL_H2 = 3'd5;
   localparam logic [2:0] SEL_H3 = 3'd6;

   typedef struct packed {
      logic       load;
      logic       head_wr;
      logic [1:0] head_idx;
      logic       mac_en;
      logic       mac_first;
      logic [1:0] k;
      logic [2:0] pt_sel;
      logic       out_load;
      logic       out_last;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic closed_match;
   } status_type;

endpackage

### rtl/cbs_ctrl.sv
// Sequencer of the B-spline point generator: path tracking, segment and sample loops.
`include "cubic_bspline_point_generator_macros.svh"

module cbs_ctrl #(
   parameter int MAX_STEPS = 16,
   parameter int SW        = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write,
   input  logic [cbs_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [cbs_pkg::CSR_DATA_W-1:0]   csr_data,
   input  logic                             req_valid,
   input  logic                             req_path_end,
   output logic                             req_ready,
   output cbs_pkg::cmd_type                 cmd,
   output logic [SW-1:0]                    step_sm1,
   output logic [SW-1:0]                    step_j,
   input  cbs_pkg::status_type              status
);
   import cbs_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_MAC,
      S_DRAIN,
      S_OUT
   } state_type;

   localparam logic [2:0] PTS_FULL = 3'd4;
   localparam logic [1:0] SEG_LAST = 2'd3;
   localparam logic [1:0] K_LAST   = 2'd3;

   state_type             state_ff, state_in;
   logic [2:0]            ps_ff, ps_in;
   logic                  end_ff, end_in;
   logic [1:0]            seg_ff, seg_in;
   logic                  tail_ff, tail_in;
   logic [1:0]            k_ff, k_in;
   logic                  drain_ff, drain_in;
   logic [SW-1:0]         j_ff, j_in;
   logic [CSR_DATA_W-1:0] steps_ff, steps_in;
   logic                  close_ff, close_in;

   logic [CSR_DATA_W-1:0] s_eff;
   logic [CSR_DATA_W-1:0] s_eff_m1;
   logic [2:0]            ps_next;
   logic                  seg_done;

   always_comb begin
      if (steps_ff == '0) begin
         s_eff = CSR_DATA_W'(1);
      end else if (steps_ff > CSR_DATA_W'(MAX_STEPS)) begin
         s_eff = CSR_DATA_W'(MAX_STEPS);
      end else begin
         s_eff = steps_ff;
      end
   end

   assign s_eff_m1 = s_eff - CSR_DATA_W'(1);
   assign step_sm1 = s_eff_m1[SW-1:0];
   assign step_j   = j_ff;
   assign ps_next  = (ps_ff == PTS_FULL) ? PTS_FULL : ps_ff + 3'd1;
   assign seg_done = tail_ff || (j_ff == step_sm1);
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      ps_in    = ps_ff;
      end_in   = end_ff;
      seg_in   = seg_ff;
      tail_in  = tail_ff;
      k_in     = k_ff;
      drain_in = drain_ff;
      j_in     = j_ff;
      steps_in = steps_ff;
      close_in = close_ff;
      cmd      = '0;

      if (csr_write) begin
         case (csr_index)
            CSR_STEPS: begin
               steps_in = csr_data;
            end
            CSR_CLOSE_MODE: begin
               close_in = csr_data[0];
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load     = 1'b1;
               cmd.head_wr  = (ps_ff != PTS_FULL);
               cmd.head_idx = ps_ff[1:0];
               end_in       = req_path_end;
               ps_in        = req_path_end ? 3'd0 : ps_next;
               seg_in       = '0;
               tail_in      = 1'b0;
               k_in         = '0;
               j_in         = '0;
               if (ps_next == PTS_FULL) begin
                  state_in = S_MAC;
               end
            end
         end
         S_MAC: begin
            cmd.mac_en    = 1'b1;
            cmd.mac_first = (k_ff == 2'd0);
            cmd.k         = k_ff;
            if (tail_ff) begin
               // The end point repeats the newest window point in the last tap.
               cmd.pt_sel = (k_ff == K_LAST) ? SEL_W3 : SEL_W1 + 3'(k_ff);
            end else begin
               cmd.pt_sel = SEL_W0 + 3'(seg_ff) + 3'(k_ff);
            end
            k_in = k_ff + 2'd1;
            if (k_ff == K_LAST) begin
               state_in = S_DRAIN;
               drain_in = 1'b0;
            end
         end
         S_DRAIN: begin
            drain_in = 1'b1;
            if (drain_ff) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_last = end_ff && (tail_ff || (seg_done && seg_ff == SEG_LAST));
               if (!seg_done) begin
                  j_in     = j_ff + SW'(1);
                  state_in = S_MAC;
               end else if (!end_ff || tail_ff || seg_ff == SEG_LAST) begin
                  state_in = S_IDLE;
               end else if (seg_ff == 2'd0 && !(close_ff && status.closed_match)) begin
                  tail_in  = 1'b1;
                  j_in     = '0;
                  state_in = S_MAC;
               end else begin
                  seg_in   = seg_ff + 2'd1;
                  j_in     = '0;
                  state_in = S_MAC;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ps_ff    <= '0;
         end_ff   <= 1'b0;
         seg_ff   <= '0;
         tail_ff  <= 1'b0;
         k_ff     <= '0;
         drain_ff <= 1'b0;
         j_ff     <= '0;
         steps_ff <= STEPS_RESET;
         close_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ps_ff    <= ps_in;
         end_ff   <= end_in;
         seg_ff   <= seg_in;
         tail_ff  <= tail_in;
         k_ff     <= k_in;
         drain_ff <= drain_in;
         j_ff     <= j_in;
         steps_ff <= steps_in;
         close_ff <= close_in;
      end
   end

   `CBS_ASSERT_IMPL(a_load_when_free, clock, reset, cmd.out_load, status.out_free)
   `CBS_ASSERT_IMPL(a_sample_in_range, clock, reset, state_ff == S_MAC, j_ff <= step_sm1)
   `CBS_ASSERT_IMPL(a_tail_first_seg, clock, reset, tail_ff, seg_ff == 2'd0 && j_ff == '0)

endmodule

### rtl/cbs_dpath.sv
// Datapath of the B-spline point generator: point stores, weight table, MAC and rounding.
`include "cubic_bspline_point_generator_macros.svh"

module cbs_dpath #(
   parameter int COORD_BITS       = 24,
   parameter int WEIGHT_FRAC_BITS = 16,
   parameter int MAX_STEPS        = 16,
   parameter int SW               = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic signed [COORD_BITS-1:0]  req_point_x,
   input  logic signed [COORD_BITS-1:0]  req_point_y,
   input  cbs_pkg::cmd_type              cmd,
   input  logic [SW-1:0]                 step_sm1,
   input  logic [SW-1:0]                 step_j,
   output cbs_pkg::status_type           status,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [COORD_BITS-1:0]  rsp_curve_x,
   output logic signed [COORD_BITS-1:0]  rsp_curve_y,
   output logic                          rsp_curve_last
);
   import cbs_pkg::*;

   localparam int WFB = WEIGHT_FRAC_BITS;
   localparam int PW  = COORD_BITS + WFB + 1;
   localparam int AW  = PW + 2;
   localparam int RW  = AW - WFB;

   localparam logic signed [AW-1:0] HALF = {{(AW-1){1'b0}}, 1'b1} << (WFB - 1);
   localparam logic signed [RW-1:0] SAT_HI =
      {{(RW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [RW-1:0] SAT_LO = ~SAT_HI;

   logic signed [COORD_BITS-1:0] win_x_ff  [4];
   logic signed [COORD_BITS-1:0] win_y_ff  [4];
   logic signed [COORD_BITS-1:0] head_x_ff [4];
   logic signed [COORD_BITS-1:0] head_y_ff [4];

   logic [WFB-1:0] wt_tab [4][MAX_STEPS][MAX_STEPS];

   logic signed [COORD_BITS-1:0] sel_x, sel_y;
   logic signed [COORD_BITS-1:0] opx_ff, opy_ff;
   logic [WFB-1:0]               w_ff;
   logic signed [WFB:0]          w_s;
   logic                         v1_ff, f1_ff;
   logic signed [PW-1:0]         prod_x_in, prod_y_in;
   logic signed [PW-1:0]         prod_x_ff, prod_y_ff;
   logic                         v2_ff, f2_ff;
   logic signed [AW-1:0]         acc_x_ff, acc_y_ff;
   logic signed [AW-1:0]         acc_x_in, acc_y_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_BITS-1:0] curve_x_ff, curve_y_ff;
   logic                         curve_last_ff;

   // Exact rational weights for t = j/s, rounded to nearest with ties up.
   for (genvar gs = 1; gs <= MAX_STEPS; gs++) begin : g_s
      for (genvar gj = 0; gj < MAX_STEPS; gj++) begin : g_j
         for (genvar gk = 0; gk < 4; gk++) begin : g_k
            localparam longint S   = gs;
            localparam longint J   = gj;
            localparam longint D   = S - J;
            localparam longint A   = (gk == 0) ? D * D * D :
                                     (gk == 1) ? 3 * J * J * J - 6 * J * J * S + 4 * S * S * S :
                                     (gk == 2) ? -3 * J * J * J + 3 * J * J * S + 3 * J * S * S
                                                 + S * S * S :
                                     J * J * J;
            localparam longint DEN = 6 * S * S * S;
            localparam longint WV  = (gj < gs) ? ((A << WFB) + DEN / 2) / DEN : 0;
            assign wt_tab[gk][gs-1][gj] = WV[WFB-1:0];
         end
      end
   end

   function automatic logic signed [COORD_BITS-1:0] round_sat(input logic signed [AW-1:0] acc);
      logic signed [AW-1:0] biased;
      logic signed [RW-1:0] r;
      biased = acc + HALF;
      r      = biased[AW-1:WFB];
      if (r > SAT_HI) begin
         return SAT_HI[COORD_BITS-1:0];
      end else if (r < SAT_LO) begin
         return SAT_LO[COORD_BITS-1:0];
      end
      return r[COORD_BITS-1:0];
   endfunction

   always_comb begin
      case (cmd.pt_sel)
         SEL_W0: begin
            sel_x = win_x_ff[0];
            sel_y = win_y_ff[0];
         end
         SEL_W1: begin
            sel_x = win_x_ff[1];
            sel_y = win_y_ff[1];
         end
         SEL_W2: begin
            sel_x = win_x_ff[2];
            sel_y = win_y_ff[2];
         end
         SEL_W3: begin
            sel_x = win_x_ff[3];
            sel_y = win_y_ff[3];
         end
         SEL_H1: begin
            sel_x = head_x_ff[1];
            sel_y = head_y_ff[1];
         end
         SEL_H2: begin
            sel_x = head_x_ff[2];
            sel_y = head_y_ff[2];
         end
         SEL_H3: begin
            sel_x = head_x_ff[3];
            sel_y = head_y_ff[3];
         end
         default: begin
            sel_x = win_x_ff[0];
            sel_y = win_y_ff[0];
         end
      endcase
   end

   assign w_s       = $signed({1'b0, w_ff});
   assign prod_x_in = PW'(opx_ff) * PW'(w_s);
   assign prod_y_in = PW'(opy_ff) * PW'(w_s);
   assign acc_x_in  = (f2_ff ? AW'(0) : acc_x_ff) + AW'(prod_x_ff);
   assign acc_y_in  = (f2_ff ? AW'(0) : acc_y_ff) + AW'(prod_y_ff);

   assign status.out_free     = !rsp_valid_ff || rsp_ready;
   assign status.closed_match = (win_x_ff[3] == head_x_ff[0]) && (win_y_ff[3] == head_y_ff[0]);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= cmd.mac_en;
         v2_ff        <= v1_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         win_x_ff[0] <= win_x_ff[1];
         win_x_ff[1] <= win_x_ff[2];
         win_x_ff[2] <= win_x_ff[3];
         win_x_ff[3] <= req_point_x;
         win_y_ff[0] <= win_y_ff[1];
         win_y_ff[1] <= win_y_ff[2];
         win_y_ff[2] <= win_y_ff[3];
         win_y_ff[3] <= req_point_y;
         if (cmd.head_wr) begin
            head_x_ff[cmd.head_idx] <= req_point_x;
            head_y_ff[cmd.head_idx] <= req_point_y;
         end
      end
      opx_ff    <= sel_x;
      opy_ff    <= sel_y;
      w_ff      <= wt_tab[cmd.k][step_sm1][step_j];
      f1_ff     <= cmd.mac_first;
      prod_x_ff <= prod_x_in;
      prod_y_ff <= prod_y_in;
      f2_ff     <= f1_ff;
      if (v2_ff) begin
         acc_x_ff <= acc_x_in;
         acc_y_ff <= acc_y_in;
      end
      if (cmd.out_load) begin
         curve_x_ff    <= round_sat(acc_x_ff);
         curve_y_ff    <= round_sat(acc_y_ff);
         curve_last_ff <= cmd.out_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_curve_x    = curve_x_ff;
   assign rsp_curve_y    = curve_y_ff;
   assign rsp_curve_last = curve_last_ff;

   `CBS_ASSERT_IMPL(a_out_after_drain, clock, reset, cmd.out_load, !v1_ff && !v2_ff)
   `CBS_ASSERT_IMPL(a_load_when_quiet, clock, reset, cmd.load, !v1_ff && !v2_ff && !cmd.mac_en)
   `CBS_ASSERT_IMPL(a_pipe_order, clock, reset, v2_ff, $past(v1_ff))

endmodule

### rtl/cubic_bspline_point_generator.sv
// Top level of the uniform cubic B-spline point generator.
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_ready  req_point_x, req_point_y, req_path_end
//   rsp      out        rsp_valid/rsp_ready  rsp_curve_x, rsp_curve_y, rsp_curve_last
//   csr      in         csr_write            csr_index, csr_data
//
// Each curve sample takes four multiply-accumulate steps on one x/y multiplier pair,
// a drain of the product pipeline and one result load. A control point that fills the
// window yields steps samples; a path's last point adds steps samples for each of the three
// wrap-around segments of a closed curve, or one sample for the end point otherwise.
// Reset is synchronous and clears the sequencer and handshake state; the point stores are
// written before they are read and need no clearing.
// A stalled result channel holds the sequencer at its load step; a new point is taken as
// soon as the last sample of the previous one sits in the output register.
module cubic_bspline_point_generator #(
   parameter int COORD_BITS       = 24,
   parameter int WEIGHT_FRAC_BITS = 16,
   parameter int MAX_STEPS        = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write,
   input  logic [cbs_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [cbs_pkg::CSR_DATA_W-1:0]   csr_data,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [COORD_BITS-1:0]     req_point_x,
   input  logic signed [COORD_BITS-1:0]     req_point_y,
   input  logic                             req_path_end,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [COORD_BITS-1:0]     rsp_curve_x,
   output logic signed [COORD_BITS-1:0]     rsp_curve_y,
   output logic                             rsp_curve_last
);
   import cbs_pkg::*;

   localparam int SW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

   cmd_type       cmd;
   status_type    status;
   logic [SW-1:0] step_sm1;
   logic [SW-1:0] step_j;

   cbs_ctrl #(
      .MAX_STEPS (MAX_STEPS),
      .SW        (SW)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .req_valid    (req_valid),
      .req_path_end (req_path_end),
      .req_ready    (req_ready),
      .cmd          (cmd),
      .step_sm1     (step_sm1),
      .step_j       (step_j),
      .status       (status)
   );

   cbs_dpath #(
      .COORD_BITS       (COORD_BITS),
      .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS),
      .MAX_STEPS        (MAX_STEPS),
      .SW               (SW)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_point_x    (req_point_x),
      .req_point_y    (req_point_y),
      .cmd            (cmd),
      .step_sm1       (step_sm1),
      .step_j         (step_j),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_curve_x    (rsp_curve_x),
      .rsp_curve_y    (rsp_curve_y),
      .rsp_curve_last (rsp_curve_last)
   );

endmodule
